>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the sorted priority queue.
// No dependencies; every other file imports this package.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_W    = 8;
  localparam int PAYLOAD_W = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                 enq;       // insert new entry this cycle
    logic                 deq;       // pop head this cycle
    logic [PRIO_W-1:0]    new_prio;
    logic [PAYLOAD_W-1:0] new_payload;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/spq_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready handshake).
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_req_if import spq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [PRIO_W-1:0]    priority_req;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output action, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input action, input priority_req, input payload,
                  output ready);
endinterface

interface spq_res_if import spq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [PRIO_W-1:0]    out_priority;
  logic [1:0]           status;
  logic [CNT_W-1:0]     count;
  logic                 empty_res;

  modport source (output valid, output out_payload, output out_priority, output status,
                  output count, output empty_res, input ready);
  modport sink   (input valid, input out_payload, input out_priority, input status,
                  input count, input empty_res, output ready);
endinterface

`default_nettype wire

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted shift-register queue.
// Depends on spq_pkg (cell_ctrl_t, widths).
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 occ,          // slot holds a live entry
  input  wire logic                 left_keep,    // upstream slot stays put
  input  wire logic [PRIO_W-1:0]    left_prio,
  input  wire logic [PAYLOAD_W-1:0] left_payload,
  input  wire logic [PRIO_W-1:0]    right_prio,
  input  wire logic [PAYLOAD_W-1:0] right_payload,
  output logic                      keep,
  output logic [PRIO_W-1:0]         prio,
  output logic [PAYLOAD_W-1:0]      payload
);

  // Equal priorities stay ahead of the new entry: FIFO among ties
  assign keep = occ && (prio >= ctrl.new_prio);

  always_ff @(posedge clk) begin
    priority if (ctrl.enq && !keep) begin
      if (left_keep) begin
        prio    <= ctrl.new_prio;
        payload <= ctrl.new_payload;
      end else begin
        prio    <= left_prio;
        payload <= left_payload;
      end
    end else if (ctrl.deq) begin
      prio    <= right_prio;
      payload <= right_payload;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue top level: controller, cell chain, result register.
// Depends on spq_pkg, spq_if (spq_req_if, spq_res_if) and spq_cell.
// Each op is a single parallel shift of the cell chain; its result is registered.
// Throughput: 1 request per cycle while the result channel is not back-pressured.
// Reset (rst, synchronous): count cleared to zero, result register emptied.
// Slot contents are not reset; a slot is live only below the entry count.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  spq_req_if.sink   req,
  spq_res_if.source res
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic accept;
  logic is_full;
  logic is_empty;
  logic do_enq;
  logic do_deq;

  cell_ctrl_t ctrl;

  logic                 occ       [CAPACITY];
  logic                 keep      [CAPACITY];
  logic [PRIO_W-1:0]    c_prio    [CAPACITY];
  logic [PAYLOAD_W-1:0] c_payload [CAPACITY];

  // Result register: a new request enters while the old result drains
  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign do_enq   = accept && (req.action == ACT_ENQ) && !is_full;
  assign do_deq   = accept && (req.action == ACT_DEQ) && !is_empty;

  assign ctrl.enq         = do_enq;
  assign ctrl.deq         = do_deq;
  assign ctrl.new_prio    = req.priority_req;
  assign ctrl.new_payload = req.payload;

  // Cell chain: slot 0 is the head. On insert each non-keeping slot takes
  // either the new entry (boundary) or its left neighbor; on pop every slot
  // takes its right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 lk;
    logic [PRIO_W-1:0]    lp;
    logic [PAYLOAD_W-1:0] ld;
    logic [PRIO_W-1:0]    rp;
    logic [PAYLOAD_W-1:0] rd;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lp = '0;
      assign ld = '0;
    end else begin : g_mid
      assign lk = keep[i-1];
      assign lp = c_prio[i-1];
      assign ld = c_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // Tail slot falls out of the live range on pop
      assign rp = '0;
      assign rd = '0;
    end else begin : g_body
      assign rp = c_prio[i+1];
      assign rd = c_payload[i+1];
    end

    spq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occ           (occ[i]),
      .left_keep     (lk),
      .left_prio     (lp),
      .left_payload  (ld),
      .right_prio    (rp),
      .right_payload (rd),
      .keep          (keep[i]),
      .prio          (c_prio[i]),
      .payload       (c_payload[i])
    );
  end

  always_comb begin
    priority if (do_enq) begin
      count_next = count + CNT_W'(1);
    end else if (do_deq) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.count     <= count_next;
      res.empty_res <= (count_next == '0);
      unique case (req.action)
        ACT_ENQ: begin
          res.out_payload  <= '0;
          res.out_priority <= '0;
          res.status       <= is_full ? ST_FULL : ST_OK;
        end
        ACT_DEQ, ACT_PEEK: begin
          if (is_empty) begin
            res.out_payload  <= '0;
            res.out_priority <= '0;
            res.status       <= ST_EMPTY;
          end else begin
            res.out_payload  <= c_payload[0];
            res.out_priority <= c_prio[0];
            res.status       <= ST_OK;
          end
        end
        default: begin
          // unused code: no-op, status ok
          res.out_payload  <= '0;
          res.out_priority <= '0;
          res.status       <= ST_OK;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    do_enq |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    occ[1] |-> c_prio[0] >= c_prio[1])
    else $error("head slot out of order");

  a_tail_free: assert property (@(posedge clk) disable iff (rst)
    do_enq |-> !keep[CAPACITY-1])
    else $error("insert with a live tail slot");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.empty_res == (res.count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_EMPTY) |-> (res.count == '0))
    else $error("empty error with live entries");

endmodule

`default_nettype wire
